@@ hdl/damped_follow_velocity_controller_defines.svh @@
// Assertion macros shared by the damped follow velocity controller.
`ifndef DAMPED_FOLLOW_VELOCITY_CONTROLLER_DEFINES_SVH
`define DAMPED_FOLLOW_VELOCITY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DFVC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DFVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/dfvc_pkg.sv @@
// Types, constants and register map of the damped follow velocity controller.
`timescale 1ns / 1ps

package dfvc_pkg;

   // Request kinds
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_PRIMARY   = 2'd1;
   localparam logic [1:0] REQ_SECONDARY = 2'd2;

   // Register map, index = paddr[4:2]
   localparam int          PADDR_W     = 5;
   localparam logic [2:0]  REG_ENABLE  = 3'd0;
   localparam logic [2:0]  REG_DEAD    = 3'd1;
   localparam logic [2:0]  REG_DAMPING = 3'd2;
   localparam logic [2:0]  REG_SP_X    = 3'd3;
   localparam logic [2:0]  REG_SP_Z    = 3'd4;
   localparam logic [2:0]  REG_GAIN_X  = 3'd5;
   localparam logic [2:0]  REG_GAIN_Z  = 3'd6;
   localparam logic [2:0]  REG_LIMIT   = 3'd7;

   // Register reset values
   localparam logic               RST_ENABLE  = 1'b1;
   localparam logic [14:0]        RST_DEAD    = 15'd26;
   localparam logic [7:0]         RST_DAMPING = 8'd30;
   localparam logic signed [15:0] RST_SP_X    = 16'sd0;
   localparam logic signed [15:0] RST_SP_Z    = 16'sd154;
   localparam logic signed [15:0] RST_GAIN_X  = 16'sd1280;
   localparam logic signed [15:0] RST_GAIN_Z  = 16'sd256;
   localparam logic [14:0]        RST_LIMIT   = 15'd256;

   // Default secondary hold-off in milliseconds
   localparam int HOLD_OFF_MS_DEF = 500;

   // Arithmetic widths: numerator, dividend (numerator magnitude / 256), divisor
   localparam int NUM_W       = 34;
   localparam int DVD_W       = 24;
   localparam int DVS_W       = 9;
   localparam int DIV_BITS    = 2;
   localparam int DIV_CYCLES  = DVD_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] target_x_pos;
      logic signed [15:0] target_z_pos;
      logic [31:0]        time_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] linear_cmd;
      logic signed [15:0] angular_cmd;
   } rsp_item_type;

   typedef struct packed {
      logic               enable;
      logic [14:0]        dead_band;
      logic [7:0]         damping;
      logic signed [15:0] setpoint_x;
      logic signed [15:0] setpoint_z;
      logic signed [15:0] gain_x;
      logic signed [15:0] gain_z;
      logic [14:0]        speed_limit;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic tgt_primary;
      logic tgt_secondary;
      logic err_en;
      logic mul_en;
      logic sum_en;
      logic div_load;
      logic div_step;
      logic commit;
   } cmd_type;

endpackage

@@ hdl/dfvc_div.sv @@
// Restoring unsigned divider lane, two quotient bits per step.
`timescale 1ns / 1ps

module dfvc_div (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [dfvc_pkg::DVD_W-1:0]    dividend,
   input  logic [dfvc_pkg::DVS_W-1:0]    divisor,
   output logic [dfvc_pkg::DVD_W-1:0]    quotient
);

   logic [dfvc_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [dfvc_pkg::DVS_W-1:0] rem_ff, rem_in;

   // Two dependent shift-and-subtract steps; quotient bits shift in at the bottom.
   always_comb begin
      logic [dfvc_pkg::DVD_W-1:0] d;
      logic [dfvc_pkg::DVS_W-1:0] r;
      logic [dfvc_pkg::DVS_W:0]   sh;
      d = dvd_ff;
      r = rem_ff;
      for (int i = 0; i < dfvc_pkg::DIV_BITS; i++) begin
         sh = {r, d[dfvc_pkg::DVD_W-1]};
         if (sh >= {1'b0, divisor}) begin
            sh = sh - {1'b0, divisor};
            d  = {d[dfvc_pkg::DVD_W-2:0], 1'b1};
         end else begin
            d  = {d[dfvc_pkg::DVD_W-2:0], 1'b0};
         end
         r = sh[dfvc_pkg::DVS_W-1:0];
      end
      if (load) begin
         dvd_in = dividend;
         rem_in = '0;
      end else if (step) begin
         dvd_in = d;
         rem_in = r;
      end else begin
         dvd_in = dvd_ff;
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient = dvd_ff;

endmodule

@@ hdl/dfvc_ctrl.sv @@
// Sequencing state machine of the damped follow velocity controller.
`timescale 1ns / 1ps

module dfvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_type,
   input  logic                enable,
   input  logic                out_free,
   output logic                busy,
   output dfvc_pkg::cmd_type   cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ERR  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_POST = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [dfvc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = req_valid && !busy;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.tgt_primary   = accept && (req_type == dfvc_pkg::REQ_PRIMARY);
            cmd.tgt_secondary = accept && (req_type == dfvc_pkg::REQ_SECONDARY);
            if (accept && (req_type == dfvc_pkg::REQ_TICK) && enable) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == dfvc_pkg::DIV_CNT_W'(dfvc_pkg::DIV_CYCLES - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ hdl/dfvc_dp.sv @@
// Datapath: target latch, error, products, damped division and output shaping.
`timescale 1ns / 1ps

module dfvc_dp #(
   parameter int HOLD_OFF_MS = dfvc_pkg::HOLD_OFF_MS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dfvc_pkg::cmd_type       cmd,
   input  dfvc_pkg::cfg_type       cfg,
   input  dfvc_pkg::req_item_type  req_data,
   output dfvc_pkg::rsp_item_type  result
);

   // Controller state
   logic signed [15:0] latched_x_ff, latched_x_in;
   logic signed [15:0] latched_z_ff, latched_z_in;
   logic signed [15:0] prev_lin_ff, prev_lin_in;
   logic signed [15:0] prev_ang_ff, prev_ang_in;
   logic [31:0]        stamp_ff, stamp_in;

   // Pipeline registers
   logic signed [16:0] err_x_ff, err_x_in, err_z_ff, err_z_in;
   logic signed [24:0] pp_lin_ff, pp_lin_in, pp_ang_ff, pp_ang_in;
   logic signed [32:0] pe_lin_ff, pe_lin_in, pe_ang_ff, pe_ang_in;
   logic               sgn_lin_ff, sgn_lin_in, sgn_ang_ff, sgn_ang_in;
   logic [dfvc_pkg::DVD_W-1:0] dvd_lin_ff, dvd_lin_in, dvd_ang_ff, dvd_ang_in;

   logic signed [dfvc_pkg::NUM_W-1:0] num_lin, num_ang, mag_lin, mag_ang;
   logic [dfvc_pkg::DVS_W-1:0] divisor;
   logic [dfvc_pkg::DVD_W-1:0] q_lin, q_ang;
   logic [31:0]                since_primary;
   logic                       hold_pass;
   logic signed [15:0]         lin_cmd, ang_val, ang_neg;
   logic [14:0]                lin_mag;

   // Secondary targets inside the hold-off window are dropped
   assign since_primary = req_data.time_ms - stamp_ff;
   assign hold_pass     = (since_primary >= 32'(HOLD_OFF_MS));

   // Target latch and primary timestamp; an enabled tick returns the target to setpoint
   always_comb begin
      latched_x_in = latched_x_ff;
      latched_z_in = latched_z_ff;
      stamp_in     = stamp_ff;
      if (cmd.tgt_primary) begin
         stamp_in     = req_data.time_ms;
         latched_x_in = req_data.target_x_pos;
         latched_z_in = req_data.target_z_pos;
      end else if (cmd.tgt_secondary && hold_pass) begin
         latched_x_in = req_data.target_x_pos;
         latched_z_in = req_data.target_z_pos;
      end else if (cmd.commit) begin
         latched_x_in = cfg.setpoint_x;
         latched_z_in = cfg.setpoint_z;
      end
   end

   // Errors against the setpoints, exact in 17 bits
   assign err_x_in = cmd.err_en ? ({latched_x_ff[15], latched_x_ff} -
                                   {cfg.setpoint_x[15], cfg.setpoint_x}) : err_x_ff;
   assign err_z_in = cmd.err_en ? ({latched_z_ff[15], latched_z_ff} -
                                   {cfg.setpoint_z[15], cfg.setpoint_z}) : err_z_ff;

   // Damping times previous command, and error times gain
   assign pp_lin_in = cmd.mul_en ? $signed({1'b0, cfg.damping}) * prev_lin_ff : pp_lin_ff;
   assign pp_ang_in = cmd.mul_en ? $signed({1'b0, cfg.damping}) * prev_ang_ff : pp_ang_ff;
   assign pe_lin_in = cmd.mul_en ? err_z_ff * cfg.gain_z : pe_lin_ff;
   assign pe_ang_in = cmd.mul_en ? err_x_ff * cfg.gain_x : pe_ang_ff;

   // Numerator in signed 34-bit Q26.8, split into sign and magnitude / 256
   assign num_lin = {{(dfvc_pkg::NUM_W - 33){pp_lin_ff[24]}}, pp_lin_ff, 8'd0} +
                    {{(dfvc_pkg::NUM_W - 33){pe_lin_ff[32]}}, pe_lin_ff};
   assign num_ang = {{(dfvc_pkg::NUM_W - 33){pp_ang_ff[24]}}, pp_ang_ff, 8'd0} +
                    {{(dfvc_pkg::NUM_W - 33){pe_ang_ff[32]}}, pe_ang_ff};
   assign mag_lin = num_lin[dfvc_pkg::NUM_W-1] ? -num_lin : num_lin;
   assign mag_ang = num_ang[dfvc_pkg::NUM_W-1] ? -num_ang : num_ang;

   assign sgn_lin_in = cmd.sum_en ? num_lin[dfvc_pkg::NUM_W-1] : sgn_lin_ff;
   assign sgn_ang_in = cmd.sum_en ? num_ang[dfvc_pkg::NUM_W-1] : sgn_ang_ff;
   assign dvd_lin_in = cmd.sum_en ? mag_lin[dfvc_pkg::DVD_W+7:8] : dvd_lin_ff;
   assign dvd_ang_in = cmd.sum_en ? mag_ang[dfvc_pkg::DVD_W+7:8] : dvd_ang_ff;

   // Divisor is damping + 1; the 256 scale was taken off the dividend
   assign divisor = {1'b0, cfg.damping} + dfvc_pkg::DVS_W'(1);

   dfvc_div u_div_lin (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_lin_ff),
      .divisor  (divisor),
      .quotient (q_lin)
   );

   dfvc_div u_div_ang (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_ang_ff),
      .divisor  (divisor),
      .quotient (q_ang)
   );

   // Linear command: dead band, then clamp to the speed limit
   always_comb begin
      if (q_lin < {9'd0, cfg.dead_band}) begin
         lin_mag = '0;
      end else if (q_lin > {9'd0, cfg.speed_limit}) begin
         lin_mag = cfg.speed_limit;
      end else begin
         lin_mag = q_lin[14:0];
      end
      lin_cmd = sgn_lin_ff ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
   end

   // Angular command: dead band, 16-bit saturation, then saturating negation
   always_comb begin
      if (q_ang < {9'd0, cfg.dead_band}) begin
         ang_val = '0;
      end else if (!sgn_ang_ff) begin
         ang_val = (q_ang > 24'd32767) ? 16'sh7FFF : $signed(q_ang[15:0]);
      end else begin
         ang_val = (q_ang >= 24'd32768) ? 16'sh8000 : -$signed(q_ang[15:0]);
      end
      ang_neg = (ang_val == 16'sh8000) ? 16'sh7FFF : -ang_val;
   end

   assign prev_lin_in = cmd.commit ? lin_cmd : prev_lin_ff;
   assign prev_ang_in = cmd.commit ? ang_val : prev_ang_ff;

   assign result.linear_cmd  = lin_cmd;
   assign result.angular_cmd = ang_neg;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_x_ff <= dfvc_pkg::RST_SP_X;
         latched_z_ff <= dfvc_pkg::RST_SP_Z;
         prev_lin_ff  <= '0;
         prev_ang_ff  <= '0;
         stamp_ff     <= '0;
      end else begin
         latched_x_ff <= latched_x_in;
         latched_z_ff <= latched_z_in;
         prev_lin_ff  <= prev_lin_in;
         prev_ang_ff  <= prev_ang_in;
         stamp_ff     <= stamp_in;
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      err_x_ff   <= err_x_in;
      err_z_ff   <= err_z_in;
      pp_lin_ff  <= pp_lin_in;
      pp_ang_ff  <= pp_ang_in;
      pe_lin_ff  <= pe_lin_in;
      pe_ang_ff  <= pe_ang_in;
      sgn_lin_ff <= sgn_lin_in;
      sgn_ang_ff <= sgn_ang_in;
      dvd_lin_ff <= dvd_lin_in;
      dvd_ang_ff <= dvd_ang_in;
   end

endmodule

@@ hdl/damped_follow_velocity_controller.sv @@
// Damped follow velocity controller top level: register port, output register, units.
// Target requests do not make the block busy and may arrive back to back while it is idle.
// A tick request passes through error, products, sum, load, 12 two-bit divide steps and
// commit; no new request is taken until the commit, which waits for a free output register.
// Synchronous active-high reset restores register defaults and clears the state.
`timescale 1ns / 1ps

`include "damped_follow_velocity_controller_defines.svh"

module damped_follow_velocity_controller #(
   parameter int HOLD_OFF_MS = dfvc_pkg::HOLD_OFF_MS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dfvc_pkg::req_item_type           req_data,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dfvc_pkg::rsp_item_type           rsp_data,
   // Register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dfvc_pkg::PADDR_W-1:0]     paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   dfvc_pkg::cfg_type      cfg_ff, cfg_in;
   dfvc_pkg::cmd_type      cmd;
   dfvc_pkg::rsp_item_type result;
   dfvc_pkg::rsp_item_type rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   busy, out_free, cfg_wr;
   logic [2:0]             reg_idx;
   logic                   tick_go;

   assign pready  = 1'b1;
   assign reg_idx = paddr[dfvc_pkg::PADDR_W-1:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_idx)
            dfvc_pkg::REG_ENABLE:  cfg_in.enable      = pwdata[0];
            dfvc_pkg::REG_DEAD:    cfg_in.dead_band   = pwdata[14:0];
            dfvc_pkg::REG_DAMPING: cfg_in.damping     = pwdata[7:0];
            dfvc_pkg::REG_SP_X:    cfg_in.setpoint_x  = pwdata[15:0];
            dfvc_pkg::REG_SP_Z:    cfg_in.setpoint_z  = pwdata[15:0];
            dfvc_pkg::REG_GAIN_X:  cfg_in.gain_x      = pwdata[15:0];
            dfvc_pkg::REG_GAIN_Z:  cfg_in.gain_z      = pwdata[15:0];
            dfvc_pkg::REG_LIMIT:   cfg_in.speed_limit = pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads, signed fields sign-extended
   always_comb begin
      case (reg_idx)
         dfvc_pkg::REG_ENABLE:  prdata = {31'd0, cfg_ff.enable};
         dfvc_pkg::REG_DEAD:    prdata = {17'd0, cfg_ff.dead_band};
         dfvc_pkg::REG_DAMPING: prdata = {24'd0, cfg_ff.damping};
         dfvc_pkg::REG_SP_X:    prdata = {{16{cfg_ff.setpoint_x[15]}}, cfg_ff.setpoint_x};
         dfvc_pkg::REG_SP_Z:    prdata = {{16{cfg_ff.setpoint_z[15]}}, cfg_ff.setpoint_z};
         dfvc_pkg::REG_GAIN_X:  prdata = {{16{cfg_ff.gain_x[15]}}, cfg_ff.gain_x};
         dfvc_pkg::REG_GAIN_Z:  prdata = {{16{cfg_ff.gain_z[15]}}, cfg_ff.gain_z};
         dfvc_pkg::REG_LIMIT:   prdata = {17'd0, cfg_ff.speed_limit};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable      <= dfvc_pkg::RST_ENABLE;
         cfg_ff.dead_band   <= dfvc_pkg::RST_DEAD;
         cfg_ff.damping     <= dfvc_pkg::RST_DAMPING;
         cfg_ff.setpoint_x  <= dfvc_pkg::RST_SP_X;
         cfg_ff.setpoint_z  <= dfvc_pkg::RST_SP_Z;
         cfg_ff.gain_x      <= dfvc_pkg::RST_GAIN_X;
         cfg_ff.gain_z      <= dfvc_pkg::RST_GAIN_Z;
         cfg_ff.speed_limit <= dfvc_pkg::RST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Controller and datapath
   dfvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_data.req_type),
      .enable    (cfg_ff.enable),
      .out_free  (out_free),
      .busy      (busy),
      .cmd       (cmd)
   );

   dfvc_dp #(
      .HOLD_OFF_MS (HOLD_OFF_MS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .result   (result)
   );

   assign req_stall = busy;

   // Output register holds a finished result until the receiver takes it
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = cmd.commit ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An enabled tick request accepted at this edge
   assign tick_go = req_valid && !req_stall && cfg_ff.enable &&
                    (req_data.req_type == dfvc_pkg::REQ_TICK);

   // A new result only ever follows a commit of the controller
   `DFVC_ASSERT_NOW(a_result_from_commit, clock, reset, $rose(rsp_valid_ff), $past(cmd.commit), "result without commit")

   // After a commit the block is ready for the next request
   `DFVC_ASSERT_NEXT(a_idle_after_commit, clock, reset, cmd.commit, !req_stall, "busy after commit")

   // An accepted enabled tick starts the computation
   `DFVC_ASSERT_NEXT(a_tick_starts, clock, reset, tick_go, req_stall, "tick did not start")

endmodule

@@ bench/damped_follow_velocity_controller_tb.sv @@
// Self-checking testbench for the damped follow velocity controller.
`timescale 1ns / 1ps

module damped_follow_velocity_controller_tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 238;

   // Request type that the block ignores.
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   dfvc_pkg::req_item_type        req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   dfvc_pkg::rsp_item_type        rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [dfvc_pkg::PADDR_W-1:0]  paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // Register shadow used by the command predictor.
   int cfg_enable;
   int cfg_dead_band;
   int cfg_damping;
   int cfg_setpoint_x;
   int cfg_setpoint_z;
   int cfg_gain_x;
   int cfg_gain_z;
   int cfg_speed_limit;

   // Predicted controller state: latched target, last commands, primary stamp.
   int          aim_x;
   int          aim_z;
   int          last_linear;
   int          last_angular;
   int unsigned primary_ms;

   dfvc_pkg::rsp_item_type expected_cmds[$];
   int                     error_count = 0;
   int                     sender_idle_pct = 0;
   int                     receiver_stall_pct = 0;
   bit                     wide_mode = 1'b1;

   damped_follow_velocity_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #1 clock = ~clock;

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Damped update with truncation toward zero, then the dead band.
   function automatic longint damped_command(input longint prev, input longint err,
                                             input longint gain);
      longint num;
      longint den;
      longint v;
      num = longint'(cfg_damping) * prev * 256 + err * gain;
      den = (longint'(cfg_damping) + 1) * 256;
      v = num / den;
      if ((v < 0 ? -v : v) < longint'(cfg_dead_band)) v = 0;
      return v;
   endfunction

   // Advance the predicted state by one accepted request and queue any command.
   task automatic apply_request(input dfvc_pkg::req_item_type r);
      int                     err_x;
      int                     err_z;
      longint                 lin;
      longint                 ang;
      longint                 neg;
      int unsigned            gap;
      dfvc_pkg::rsp_item_type cmd;
      case (r.req_type)
         dfvc_pkg::REQ_PRIMARY: begin
            primary_ms = r.time_ms;
            aim_x = $signed(r.target_x_pos);
            aim_z = $signed(r.target_z_pos);
         end
         dfvc_pkg::REQ_SECONDARY: begin
            // Wrapped distance to the primary stamp decides the hold-off.
            gap = r.time_ms - primary_ms;
            if (gap >= dfvc_pkg::HOLD_OFF_MS_DEF) begin
               aim_x = $signed(r.target_x_pos);
               aim_z = $signed(r.target_z_pos);
            end
         end
         dfvc_pkg::REQ_TICK: begin
            if (cfg_enable != 0) begin
               err_x = aim_x - cfg_setpoint_x;
               err_z = aim_z - cfg_setpoint_z;
               lin = damped_command(last_linear, err_z, cfg_gain_z);
               ang = damped_command(last_angular, err_x, cfg_gain_x);
               if (lin > cfg_speed_limit) lin = cfg_speed_limit;
               else if (lin < -longint'(cfg_speed_limit)) lin = -longint'(cfg_speed_limit);
               if (ang > 32767) ang = 32767;
               else if (ang < -32768) ang = -32768;
               last_linear = int'(lin);
               last_angular = int'(ang);
               neg = -ang;
               if (neg > 32767) neg = 32767;
               cmd.linear_cmd = lin[15:0];
               cmd.angular_cmd = neg[15:0];
               expected_cmds = {expected_cmds, cmd};
               aim_x = cfg_setpoint_x;
               aim_z = cfg_setpoint_z;
            end
         end
         default: ;
      endcase
   endtask

   // Compare each accepted command with the oldest prediction.
   always @(posedge clock) begin
      dfvc_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("command (%0d, %0d) with nothing expected",
                                      $signed(rsp_data.linear_cmd),
                                      $signed(rsp_data.angular_cmd)));
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_data.linear_cmd !== want.linear_cmd)
               report_mismatch($sformatf("linear_cmd %0d, expected %0d",
                                         $signed(rsp_data.linear_cmd),
                                         $signed(want.linear_cmd)));
            if (rsp_data.angular_cmd !== want.angular_cmd)
               report_mismatch($sformatf("angular_cmd %0d, expected %0d",
                                         $signed(rsp_data.angular_cmd),
                                         $signed(want.angular_cmd)));
         end
      end
   end

   function automatic dfvc_pkg::req_item_type make_request(input logic [1:0] kind,
                                                           input int x, input int z,
                                                           input logic [31:0] t);
      dfvc_pkg::req_item_type r;
      r.req_type = kind;
      r.target_x_pos = x[15:0];
      r.target_z_pos = z[15:0];
      r.time_ms = t;
      return r;
   endfunction

   // Send one request, idling first at the phase rate, and predict on acceptance.
   task automatic send_request(input dfvc_pkg::req_item_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      apply_request(r);
   endtask

   // Hold requests back until every command has arrived and the block is quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, access cycle, then the port is released.
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (idx)
         dfvc_pkg::REG_ENABLE:  cfg_enable = value[0];
         dfvc_pkg::REG_DEAD:    cfg_dead_band = value[14:0];
         dfvc_pkg::REG_DAMPING: cfg_damping = value[7:0];
         dfvc_pkg::REG_SP_X:    cfg_setpoint_x = $signed(value[15:0]);
         dfvc_pkg::REG_SP_Z:    cfg_setpoint_z = $signed(value[15:0]);
         dfvc_pkg::REG_GAIN_X:  cfg_gain_x = $signed(value[15:0]);
         dfvc_pkg::REG_GAIN_Z:  cfg_gain_z = $signed(value[15:0]);
         dfvc_pkg::REG_LIMIT:   cfg_speed_limit = value[14:0];
         default: ;
      endcase
   endtask

   // Ticks at the reset settings around a primary target at its extremes.
   task automatic test_reset_values();
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      send_request(make_request(dfvc_pkg::REQ_PRIMARY, 32767, -32768, 1000));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      send_request(make_request(dfvc_pkg::REQ_TICK, -1, -1, 32'hFFFF_FFFF));
   endtask

   // Secondary targets around the hold-off window, including a wrapped stamp.
   task automatic test_secondary_hold_off();
      send_request(make_request(dfvc_pkg::REQ_SECONDARY, 100, 200, 1499));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      send_request(make_request(dfvc_pkg::REQ_SECONDARY, -32768, 32767, 1500));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      // An earlier stamp counts as a large wrapped distance.
      send_request(make_request(dfvc_pkg::REQ_SECONDARY, 5, -5, 999));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      send_request(make_request(dfvc_pkg::REQ_PRIMARY, 0, 0, 32'hFFFF_FFFF));
      send_request(make_request(dfvc_pkg::REQ_SECONDARY, 1, 1, 498));
      send_request(make_request(dfvc_pkg::REQ_SECONDARY, -300, 400, 499));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
   endtask

   // A disabled tick keeps the target; an unknown request type changes nothing.
   task automatic test_disable_and_unknown();
      settle_block();
      write_register(dfvc_pkg::REG_ENABLE, 32'd0);
      send_request(make_request(dfvc_pkg::REQ_PRIMARY, 700, -700, 5000));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      send_request(make_request(REQ_RESERVED, -1234, 4321, 32'h8000_0000));
      settle_block();
      write_register(dfvc_pkg::REG_ENABLE, 32'd1);
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
   endtask

   // Zero damping, speed clamp, dead band and angular saturation at both ends.
   task automatic test_saturation_extremes();
      settle_block();
      write_register(dfvc_pkg::REG_DAMPING, 32'd0);
      write_register(dfvc_pkg::REG_DEAD, 32'd0);
      write_register(dfvc_pkg::REG_LIMIT, 32'd32767);
      write_register(dfvc_pkg::REG_GAIN_X, 32'hFFFF_8000);
      write_register(dfvc_pkg::REG_GAIN_Z, 32'hFFFF_8000);
      write_register(dfvc_pkg::REG_SP_X, 32'd32767);
      write_register(dfvc_pkg::REG_SP_Z, 32'hFFFF_8000);
      send_request(make_request(dfvc_pkg::REQ_PRIMARY, -32768, 32767, 7000));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
      settle_block();
      // Negative saturation of the stored angular value, whose negation saturates.
      write_register(dfvc_pkg::REG_GAIN_X, 32'd32767);
      write_register(dfvc_pkg::REG_LIMIT, 32'd0);
      write_register(dfvc_pkg::REG_DEAD, 32'd32767);
      send_request(make_request(dfvc_pkg::REQ_PRIMARY, -32768, 32767, 9000));
      send_request(make_request(dfvc_pkg::REQ_TICK, 0, 0, 0));
   endtask

   function automatic logic [15:0] random_position();
      if (!wide_mode) return 16'($urandom_range(4095) - 2048);
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // New settings for a random phase: every register, extremes now and then.
   task automatic randomise_config();
      int v;
      write_register(dfvc_pkg::REG_ENABLE, 32'd1);
      case ($urandom_range(4))
         0: v = 0;
         1: v = $urandom_range(32767);
         default: v = $urandom_range(64);
      endcase
      write_register(dfvc_pkg::REG_DEAD, v);
      case ($urandom_range(3))
         0: v = 0;
         1: v = 255;
         default: v = $urandom_range(255);
      endcase
      write_register(dfvc_pkg::REG_DAMPING, v);
      write_register(dfvc_pkg::REG_SP_X,
                     wide_mode ? $urandom : $urandom_range(1023) - 512);
      write_register(dfvc_pkg::REG_SP_Z,
                     wide_mode ? $urandom : $urandom_range(1023) - 512);
      write_register(dfvc_pkg::REG_GAIN_X,
                     wide_mode ? $urandom : $urandom_range(3071) - 1536);
      write_register(dfvc_pkg::REG_GAIN_Z,
                     wide_mode ? $urandom : $urandom_range(3071) - 1536);
      case ($urandom_range(4))
         0: v = 0;
         1: v = 32767;
         default: v = $urandom_range(32767);
      endcase
      write_register(dfvc_pkg::REG_LIMIT, v);
   endtask

   // Random targets and ticks under each idling pattern and several settings.
   task automatic test_random_traffic();
      int           sent;
      int           pick;
      int unsigned  offset;
      logic [1:0]   kind;
      for (int phase = 0; phase < 8; phase++) begin
         settle_block();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
         endcase
         wide_mode = (phase >= 4);
         randomise_config();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // In phase 1 the sender waits for every outstanding command once, mid-phase.
            if (phase == 1 && sent == PHASE_ITEMS / 2) settle_block();
            pick = $urandom_range(99);
            if (pick < 3) begin
               send_request(make_request(REQ_RESERVED, $urandom, $urandom, $urandom));
            end else begin
               if (pick < 35) kind = dfvc_pkg::REQ_TICK;
               else if (pick < 60) kind = dfvc_pkg::REQ_PRIMARY;
               else kind = dfvc_pkg::REQ_SECONDARY;
               // Secondary stamps fall at either side of the hold-off edge at times, else spread widely.
               case ($urandom_range(9))
                  0: offset = dfvc_pkg::HOLD_OFF_MS_DEF - 1;
                  1: offset = dfvc_pkg::HOLD_OFF_MS_DEF;
                  7, 8: offset = $urandom;
                  9: offset = -$urandom_range(600, 1);
                  default: offset = $urandom_range(1000);
               endcase
               send_request(make_request(kind, $signed(random_position()),
                                         $signed(random_position()),
                                         (kind == dfvc_pkg::REQ_PRIMARY) ? $urandom
                                                               : primary_ms + offset));
               sent++;
            end
         end
      end
   endtask

   initial begin
      cfg_enable = dfvc_pkg::RST_ENABLE;
      cfg_dead_band = dfvc_pkg::RST_DEAD;
      cfg_damping = dfvc_pkg::RST_DAMPING;
      cfg_setpoint_x = dfvc_pkg::RST_SP_X;
      cfg_setpoint_z = dfvc_pkg::RST_SP_Z;
      cfg_gain_x = dfvc_pkg::RST_GAIN_X;
      cfg_gain_z = dfvc_pkg::RST_GAIN_Z;
      cfg_speed_limit = dfvc_pkg::RST_LIMIT;
      aim_x = dfvc_pkg::RST_SP_X;
      aim_z = dfvc_pkg::RST_SP_Z;
      last_linear = 0;
      last_angular = 0;
      primary_ms = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_secondary_hold_off();
      test_disable_and_unknown();
      test_saturation_extremes();
      test_random_traffic();
      settle_block();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ damped_follow_velocity_controller.f @@
+incdir+hdl
hdl/dfvc_pkg.sv
hdl/dfvc_div.sv
hdl/dfvc_ctrl.sv
hdl/dfvc_dp.sv
hdl/damped_follow_velocity_controller.sv
bench/damped_follow_velocity_controller_tb.sv
